/* rtl/core/rnrbo_pkg.sv */
// Shared types, constants and helpers of the RNR retry backoff scheduler.
`default_nettype none
package rnrbo_pkg;
    localparam int NUM_QUEUES_DEF  = 5;
    localparam int QUEUE_DEPTH_DEF = 8;

    typedef enum logic [1:0] {
        REQ_ACK    = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ACK_OK    = 2'd0,
        ACK_RNR   = 2'd1,
        ACK_ERR   = 2'd2,
        ACK_NOACK = 2'd3
    } ack_code_t;

    typedef enum logic [2:0] {
        KIND_QUEUED   = 3'd0,
        KIND_RESEND   = 3'd1,
        KIND_OK       = 3'd2,
        KIND_ERROR    = 3'd3,
        KIND_CANCELED = 3'd4,
        KIND_FULL     = 3'd5
    } result_kind_t;

    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // One accepted input word, after decoding.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  req_id;
        logic [1:0]  ack_code;
        logic [7:0]  retry_count;
        logic [63:0] deadline_us;
        logic        canceled;
        logic [63:0] now_us;
        logic [5:0]  resend_budget;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  req;
        logic [7:0]  retries;
        logic [63:0] due;
        logic        last;
    } result_t;

    // Backoff of queue q: 1 + 10*q^3 microseconds.
    function automatic logic [63:0] backoff(input logic [2:0] q);
        logic [12:0] c;
        c = 13'(q) * 13'(q) * 13'(q);
        return 64'(14'd1 + 14'(c) * 14'd10);
    endfunction
endpackage
`default_nettype wire

/* rtl/core/rnrbo_front.sv */
// Input stage: accepts words into a short command queue.
`default_nettype none
module rnrbo_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  rnrbo_pkg::cmd_t     in_cmd,
    output logic                q_valid,
    input  wire                 q_ready,
    output rnrbo_pkg::cmd_t     q_cmd
);
    rnrbo_pkg::cmd_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) begin
                mem_reg[wp_reg] <= in_cmd;
                wp_reg <= ~wp_reg;
            end
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("command queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push && cnt_reg == 2'd1) |=> !q_valid)
        else $error("queue not empty after last pop");
endmodule
`default_nettype wire

/* rtl/core/rnrbo_back.sv */
// Execution stage: timer queues, ack handling, tick walk and cancel sweep.
`default_nettype none
module rnrbo_back #(
    parameter int NUM_QUEUES  = rnrbo_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = rnrbo_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 tx_enabled,
    input  wire                 c_valid,
    output logic                c_ready,
    input  rnrbo_pkg::cmd_t     c_cmd,
    output logic                r_valid,
    input  wire                 r_ready,
    output rnrbo_pkg::result_t  r_res
);
    localparam int NSLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int TW = $clog2(NSLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACK_CALC, ST_ACK_DEC, ST_TICK_RD, ST_TICK_EV,
        ST_MIN_RD, ST_MIN_EV, ST_CAN_RD, ST_CAN_EV, ST_EMIT
    } state_t;

    state_t state_reg;
    rnrbo_pkg::cmd_t cmd_reg;
    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [FW-1:0] fill_reg [NUM_QUEUES];
    logic [63:0]   wake_reg, best_reg, due_reg;
    logic [TW-1:0] total_reg;
    logic [QW-1:0] q_reg;
    logic [PW-1:0] k_reg;
    logic [5:0]    budget_reg;
    logic          any_reg;
    state_t        ret_reg;

    logic [9:0]  req_mem [NSLOTS];
    logic [63:0] due_mem [NSLOTS];
    logic        cm_mem  [NSLOTS];
    logic [9:0]  rd_req_reg;
    logic [63:0] rd_due_reg;
    logic        rd_cm_reg;

    rnrbo_pkg::result_t ovf_reg;

    assign c_ready = (state_reg == ST_IDLE);

    // Slot address of queue q at offset k from its head.
    function automatic logic [SW-1:0] slot(input logic [QW-1:0] q, input logic [PW-1:0] h,
                                           input logic [PW-1:0] k);
        logic [PW:0] p;
        p = ({1'b0, h} + {1'b0, k});
        if (p >= (PW+1)'(QUEUE_DEPTH)) p = p - (PW+1)'(QUEUE_DEPTH);
        return SW'(32'(q) * QUEUE_DEPTH + 32'(p));
    endfunction

    logic [QW-1:0] qsel;
    logic [64:0]   due_sum;
    always_comb begin
        if (cmd_reg.retry_count >= 8'(NUM_QUEUES)) qsel = QW'(NUM_QUEUES - 1);
        else qsel = QW'(cmd_reg.retry_count);
        due_sum = {1'b0, cmd_reg.now_us} + {1'b0, rnrbo_pkg::backoff(3'(qsel))};
    end

    always_ff @(posedge aclk) begin
        logic emit_v;
        emit_v = 1'b0;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_valid   <= 1'b0;
            wake_reg  <= rnrbo_pkg::TIME_MAX;
            total_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: if (c_valid) begin
                    cmd_reg <= c_cmd;
                    q_reg   <= '0;
                    k_reg   <= '0;
                    any_reg <= 1'b0;
                    budget_reg <= c_cmd.resend_budget;
                    best_reg   <= rnrbo_pkg::TIME_MAX;
                    unique case (rnrbo_pkg::req_type_t'(c_cmd.req_type))
                        rnrbo_pkg::REQ_ACK:    state_reg <= ST_ACK_CALC;
                        rnrbo_pkg::REQ_TICK:
                            state_reg <= (total_reg == '0 || c_cmd.now_us < wake_reg)
                                         ? ST_IDLE : ST_TICK_RD;
                        rnrbo_pkg::REQ_CANCEL: state_reg <= ST_CAN_RD;
                        default:               state_reg <= ST_IDLE;
                    endcase
                end
                ST_ACK_CALC: begin
                    due_reg   <= due_sum[64] ? rnrbo_pkg::TIME_MAX : due_sum[63:0];
                    state_reg <= ST_ACK_DEC;
                end
                ST_ACK_DEC: begin
                    ovf_reg.req  <= cmd_reg.req_id;
                    ovf_reg.last <= 1'b1;
                    ret_reg      <= ST_IDLE;
                    priority if (cmd_reg.ack_code == rnrbo_pkg::ACK_NOACK) begin
                        state_reg <= ST_IDLE;
                    end else if (cmd_reg.ack_code == rnrbo_pkg::ACK_RNR && tx_enabled
                                 && !cmd_reg.canceled) begin
                        state_reg <= ST_EMIT;
                        if (due_reg > cmd_reg.deadline_us) begin
                            ovf_reg.kind    <= rnrbo_pkg::KIND_ERROR;
                            ovf_reg.retries <= cmd_reg.retry_count;
                            ovf_reg.due     <= '0;
                        end else if (fill_reg[qsel] >= FW'(QUEUE_DEPTH)) begin
                            ovf_reg.kind    <= rnrbo_pkg::KIND_FULL;
                            ovf_reg.retries <= cmd_reg.retry_count;
                            ovf_reg.due     <= '0;
                        end else begin
                            req_mem[slot(qsel, head_reg[qsel], PW'(fill_reg[qsel]))]
                                <= cmd_reg.req_id;
                            due_mem[slot(qsel, head_reg[qsel], PW'(fill_reg[qsel]))]
                                <= due_reg;
                            cm_mem[slot(qsel, head_reg[qsel], PW'(fill_reg[qsel]))] <= 1'b0;
                            fill_reg[qsel] <= fill_reg[qsel] + FW'(1);
                            total_reg <= total_reg + TW'(1);
                            if (due_reg < wake_reg) wake_reg <= due_reg;
                            ovf_reg.kind    <= rnrbo_pkg::KIND_QUEUED;
                            ovf_reg.retries <= (cmd_reg.retry_count == 8'hFF) ? 8'hFF
                                               : cmd_reg.retry_count + 8'd1;
                            ovf_reg.due     <= due_reg;
                        end
                    end else if (cmd_reg.ack_code == rnrbo_pkg::ACK_OK) begin
                        state_reg       <= ST_EMIT;
                        ovf_reg.kind    <= rnrbo_pkg::KIND_OK;
                        ovf_reg.retries <= cmd_reg.retry_count;
                        ovf_reg.due     <= '0;
                    end else begin
                        state_reg       <= ST_EMIT;
                        ovf_reg.kind    <= cmd_reg.canceled ? rnrbo_pkg::KIND_CANCELED
                                                            : rnrbo_pkg::KIND_ERROR;
                        ovf_reg.retries <= cmd_reg.retry_count;
                        ovf_reg.due     <= '0;
                    end
                end
                ST_TICK_RD: begin
                    if (fill_reg[q_reg] == '0) begin
                        if (q_reg == QW'(NUM_QUEUES - 1)) begin
                            q_reg <= '0;
                            state_reg <= ST_MIN_RD;
                        end else q_reg <= q_reg + QW'(1);
                    end else begin
                        rd_req_reg <= req_mem[slot(q_reg, head_reg[q_reg], '0)];
                        rd_due_reg <= due_mem[slot(q_reg, head_reg[q_reg], '0)];
                        rd_cm_reg  <= cm_mem[slot(q_reg, head_reg[q_reg], '0)];
                        state_reg  <= ST_TICK_EV;
                    end
                end
                ST_TICK_EV: begin
                    priority if (rd_due_reg > cmd_reg.now_us) begin
                        if (q_reg == QW'(NUM_QUEUES - 1)) begin
                            q_reg <= '0;
                            state_reg <= ST_MIN_RD;
                        end else begin
                            q_reg <= q_reg + QW'(1);
                            state_reg <= ST_TICK_RD;
                        end
                    end else if (!rd_cm_reg && budget_reg == '0) begin
                        q_reg <= '0;
                        state_reg <= ST_MIN_RD;
                    end else if (any_reg && r_valid && !r_ready) begin
                        // The held result cannot leave yet; wait for the output register.
                    end else begin
                        if (!rd_cm_reg) budget_reg <= budget_reg - 6'd1;
                        head_reg[q_reg] <= (head_reg[q_reg] == PW'(QUEUE_DEPTH - 1))
                                           ? '0 : head_reg[q_reg] + PW'(1);
                        fill_reg[q_reg] <= fill_reg[q_reg] - FW'(1);
                        total_reg <= total_reg - TW'(1);
                        // Hold one result back so the final one can carry last.
                        if (any_reg) begin
                            r_res  <= ovf_reg;
                            emit_v = 1'b1;
                        end
                        any_reg <= 1'b1;
                        ovf_reg.kind    <= rd_cm_reg ? rnrbo_pkg::KIND_CANCELED
                                                     : rnrbo_pkg::KIND_RESEND;
                        ovf_reg.req     <= rd_req_reg;
                        ovf_reg.retries <= '0;
                        ovf_reg.due     <= '0;
                        ovf_reg.last    <= 1'b0;
                        state_reg <= ST_TICK_RD;
                    end
                end
                ST_MIN_RD: begin
                    rd_due_reg <= due_mem[slot(q_reg, head_reg[q_reg], '0)];
                    rd_cm_reg  <= (fill_reg[q_reg] != '0);
                    state_reg  <= ST_MIN_EV;
                end
                ST_MIN_EV: begin
                    if (rd_cm_reg && rd_due_reg < best_reg) best_reg <= rd_due_reg;
                    if (q_reg == QW'(NUM_QUEUES - 1)) begin
                        wake_reg <= (rd_cm_reg && rd_due_reg < best_reg) ? rd_due_reg
                                                                        : best_reg;
                        ovf_reg.last <= 1'b1;
                        ret_reg   <= ST_IDLE;
                        state_reg <= any_reg ? ST_EMIT : ST_IDLE;
                    end else begin
                        q_reg <= q_reg + QW'(1);
                        state_reg <= ST_MIN_RD;
                    end
                end
                ST_CAN_RD: begin
                    if (FW'(k_reg) >= fill_reg[q_reg] || fill_reg[q_reg] == '0) begin
                        k_reg <= '0;
                        if (q_reg == QW'(NUM_QUEUES - 1)) state_reg <= ST_IDLE;
                        else q_reg <= q_reg + QW'(1);
                    end else begin
                        rd_req_reg <= req_mem[slot(q_reg, head_reg[q_reg], k_reg)];
                        state_reg  <= ST_CAN_EV;
                    end
                end
                ST_CAN_EV: begin
                    if (rd_req_reg == cmd_reg.req_id)
                        cm_mem[slot(q_reg, head_reg[q_reg], k_reg)] <= 1'b1;
                    if (32'(k_reg) + 1 >= 32'(fill_reg[q_reg])) begin
                        k_reg <= '0;
                        if (q_reg == QW'(NUM_QUEUES - 1)) state_reg <= ST_IDLE;
                        else begin
                            q_reg <= q_reg + QW'(1);
                            state_reg <= ST_CAN_RD;
                        end
                    end else begin
                        k_reg <= k_reg + PW'(1);
                        state_reg <= ST_CAN_RD;
                    end
                end
                ST_EMIT: if (!r_valid || r_ready) begin
                    r_res     <= ovf_reg;
                    emit_v    = 1'b1;
                    state_reg <= ret_reg;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (emit_v) r_valid <= 1'b1;
            else if (r_ready) r_valid <= 1'b0;
        end
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(total_reg) <= NSLOTS) else $error("waiting count exceeds slots");
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        c_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_no_wake_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && total_reg == '0) |-> wake_reg == rnrbo_pkg::TIME_MAX
        || $past(state_reg) != ST_MIN_EV) else $error("wakeup set with no entries");
endmodule
`default_nettype wire

/* rtl/core/rnr_retry_backoff_scheduler_unit.sv */
// Top level of the RNR retry backoff scheduler: stream ports and register port.
// An ack that gives a result passes ST_ACK_CALC, ST_ACK_DEC and ST_EMIT;
// cancels and ticks walk queued entries one slot at a time, with a read
// state and an evaluate state per slot. The back end takes one word at a time.
// A two-word command queue decouples the input from the back end.
// Reset (aresetn low, synchronous) empties all queues and sets tx_enabled.
`default_nettype none
module rnr_retry_backoff_scheduler_unit #(
    parameter int NUM_QUEUES  = rnrbo_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = rnrbo_pkg::QUEUE_DEPTH_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: req_id, ack_code, retry_count, deadline_us,
    // canceled, now_us, resend_budget; zero pad to 160 bits.
    input  wire  [159:0] s_tdata,
    // Fields from bit 0: req_type.
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // Fields from bit 0: result_req, new_retry_count, due_time_us;
    // zero pad to 88 bits.
    output logic [87:0]  m_tdata,
    // Fields from bit 0: result_kind.
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [1:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic tx_en_reg;
    rnrbo_pkg::cmd_t    in_cmd, q_cmd;
    rnrbo_pkg::result_t res;
    logic q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, tx_en_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) tx_en_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == 2'd0) tx_en_reg <= pwdata[0];
    end

    assign in_cmd.req_type      = s_tuser;
    assign in_cmd.req_id        = s_tdata[9:0];
    assign in_cmd.ack_code      = s_tdata[11:10];
    assign in_cmd.retry_count   = s_tdata[19:12];
    assign in_cmd.deadline_us   = s_tdata[83:20];
    assign in_cmd.canceled      = s_tdata[84];
    assign in_cmd.now_us        = s_tdata[148:85];
    assign in_cmd.resend_budget = s_tdata[154:149];

    rnrbo_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
        .q_valid, .q_ready, .q_cmd
    );

    rnrbo_back #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk, .aresetn, .tx_enabled(tx_en_reg),
        .c_valid(q_valid), .c_ready(q_ready), .c_cmd(q_cmd),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
    );

    assign m_tdata = {6'd0, res.due, res.retries, res.req};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule
`default_nettype wire
